// ===== hdl/icrb_pkg.sv =====
`timescale 1ns / 1ps

package icrb_pkg;

    // Accumulator width: the Gaussian sum reaches 255 * 273 = 69615, the edge
    // sum spans -2040 to 2040, so 18 signed bits hold either.
    localparam int ACC_W = 18;
    localparam int WT_W  = 7;

    // floor(v / 273) == (v * GAUSS_RECIP) >> GAUSS_SHIFT for every v below 2^17.
    localparam int          GAUSS_SHIFT = 26;
    localparam logic [17:0] GAUSS_RECIP = 18'd245821;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_KERNEL = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic KERNEL_EDGE  = 1'b0;
    localparam logic KERNEL_GAUSS = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_SCALE,
        ST_EMIT
    } state_t;

    typedef logic signed [WT_W-1:0] weight_t;

    localparam weight_t GAUSS_W [5][5] = '{
        '{7'sd1, 7'sd4,  7'sd7,  7'sd4,  7'sd1},
        '{7'sd4, 7'sd16, 7'sd26, 7'sd16, 7'sd4},
        '{7'sd7, 7'sd26, 7'sd41, 7'sd26, 7'sd7},
        '{7'sd4, 7'sd16, 7'sd26, 7'sd16, 7'sd4},
        '{7'sd1, 7'sd4,  7'sd7,  7'sd4,  7'sd1}
    };

    function automatic weight_t tap_weight(input logic kernel_sel, input logic [2:0] ty,
                                           input logic [2:0] tx);
        weight_t w;
        if (kernel_sel == KERNEL_GAUSS) begin
            if (ty < 3'd5 && tx < 3'd5) begin
                w = GAUSS_W[ty][tx];
            end
            else begin
                w = '0;
            end
        end
        else begin
            w = (ty == 3'd1 && tx == 3'd1) ? 7'sd8 : -7'sd1;
        end
        return w;
    endfunction

endpackage

// ===== hdl/image_convolution_replicate_border.sv =====
`timescale 1ns / 1ps

// A pixel write gives no result and leaves the block idle. A read inside the image walks its
// N neighbours (N = 9 taps for the edge kernel, 25 for the Gaussian) through the single-port
// frame memory, one neighbour per cycle, then passes the drain, scale and emit states; a read
// outside the image goes straight to emit. No new beat is taken until the result has gone
// into the output register. Reset returns the size registers to 256 x 256 and selects the
// edge kernel; the frame memory is not cleared and holds nothing meaningful until written.
module image_convolution_replicate_border
    import icrb_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd,
    input  logic [7:0] pos_x,
    input  logic [7:0] pos_y,
    input  logic [7:0] in_red,
    input  logic [7:0] in_green,
    input  logic [7:0] in_blue,
    input  logic [7:0] in_alpha,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha,
    output logic       out_of_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    // Coordinates are eight bits wide, so a size beyond 256 behaves as 256 for every pixel
    // that can ever be written.
    localparam logic [8:0] CAP_W = (MAX_WIDTH  > 256) ? 9'd256 : 9'(MAX_WIDTH);
    localparam logic [8:0] CAP_H = (MAX_HEIGHT > 256) ? 9'd256 : 9'(MAX_HEIGHT);

    // Configuration registers. The port never holds a write back.
    logic [8:0] width_reg;
    logic [8:0] height_reg;
    logic       ksel_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            ksel_reg   <= KERNEL_EDGE;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                REG_KERNEL: ksel_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    logic [8:0] eff_w;
    logic [8:0] eff_h;

    assign eff_w = (width_reg  > CAP_W) ? CAP_W : width_reg;
    assign eff_h = (height_reg > CAP_H) ? CAP_H : height_reg;

    // Sequencer state and tap counters.
    state_t     state_reg;
    state_t     state_next;
    logic [2:0] tx_reg;
    logic [2:0] ty_reg;
    logic       tap_vld_reg;
    logic       out_valid_reg;

    logic       in_fire;
    logic       in_inside;
    logic       tap_issue;
    logic       tap_last;
    logic       out_load;
    logic [2:0] half;
    logic [2:0] last_idx;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign in_inside = ({1'b0, pos_x} < eff_w) && ({1'b0, pos_y} < eff_h);

    assign half     = (ksel_reg == KERNEL_GAUSS) ? 3'd2 : 3'd1;
    assign last_idx = (ksel_reg == KERNEL_GAUSS) ? 3'd4 : 3'd2;
    assign tap_last = (tx_reg == last_idx) && (ty_reg == last_idx);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // A read inside the image walks the neighbourhood row by row, one memory access per
    // cycle; the last sample is accumulated in the drain cycle, the Gaussian scaling is done
    // in the scale cycle, and the result goes to the output register once that register is free.
    always_comb begin
        state_next = state_reg;
        tap_issue  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && cmd == CMD_READ) begin
                    state_next = in_inside ? ST_READ : ST_EMIT;
                end
            end
            ST_READ: begin
                tap_issue = 1'b1;
                if (tap_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_EMIT;
            ST_EMIT: begin
                if (!out_valid_reg || !out_stall) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tx_reg        <= '0;
            ty_reg        <= '0;
            tap_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            tap_vld_reg <= tap_issue;
            if (in_fire) begin
                tx_reg <= '0;
                ty_reg <= '0;
            end
            else if (tap_issue) begin
                if (tx_reg == last_idx) begin
                    tx_reg <= '0;
                    ty_reg <= ty_reg + 3'd1;
                end
                else begin
                    tx_reg <= tx_reg + 3'd1;
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Neighbour coordinates, clamped to the image edge.
    function automatic logic [7:0] clamp_coord(input logic signed [9:0] v,
                                               input logic [8:0] lim);
        logic [8:0] top;
        top = lim - 9'd1;
        if (v < 10'sd0) begin
            return 8'd0;
        end
        if (v >= $signed({1'b0, lim})) begin
            return top[7:0];
        end
        return v[7:0];
    endfunction

    function automatic logic [AW-1:0] pixel_addr(input logic [7:0] x, input logic [7:0] y);
        return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    logic [7:0]        px_reg;
    logic [7:0]        py_reg;
    logic signed [9:0] nx;
    logic signed [9:0] ny;
    logic [7:0]        nx_c;
    logic [7:0]        ny_c;

    assign nx   = $signed({2'b00, px_reg}) + $signed({7'd0, tx_reg}) - $signed({7'd0, half});
    assign ny   = $signed({2'b00, py_reg}) + $signed({7'd0, ty_reg}) - $signed({7'd0, half});
    assign nx_c = clamp_coord(nx, eff_w);
    assign ny_c = clamp_coord(ny, eff_h);

    // Frame memory: one port, shared between pixel writes while idle and neighbour reads.
    logic [31:0]   frame_mem [DEPTH];
    logic [31:0]   mem_rdata_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [31:0]   mem_wdata;

    assign mem_we    = in_fire && (cmd == CMD_WRITE) && in_inside;
    assign mem_wdata = {in_alpha, in_blue, in_green, in_red};
    assign mem_addr  = (state_reg == ST_IDLE) ? pixel_addr(pos_x, pos_y)
                                              : pixel_addr(nx_c, ny_c);

    always_ff @(posedge clk) begin
        if (mem_we) begin
            frame_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= frame_mem[mem_addr];
    end

    // Weighted accumulation, one neighbour per cycle for all three colour channels.
    weight_t                  tap_wt_reg;
    logic                     tap_ctr_reg;
    logic signed [ACC_W-1:0]  acc_reg    [3];
    logic [34:0]              scaled_reg [3];
    logic signed [15:0]       tap_prod   [3];
    logic [7:0]               chan_val   [3];
    logic [7:0]               res_reg    [3];
    logic [7:0]               alpha_reg;
    logic [7:0]               out_alpha_reg;
    logic                     oor_reg;
    logic                     out_oor_reg;

    always_comb begin
        logic [8:0] q;
        q = '0;
        for (int c = 0; c < 3; c++) begin
            tap_prod[c] = tap_wt_reg * $signed({1'b0, mem_rdata_reg[8*c +: 8]});
            if (ksel_reg == KERNEL_GAUSS) begin
                q = scaled_reg[c][GAUSS_SHIFT+8:GAUSS_SHIFT];
                chan_val[c] = (q > 9'd255) ? 8'd255 : q[7:0];
            end
            else if (acc_reg[c] < 0) begin
                chan_val[c] = 8'd0;
            end
            else if (acc_reg[c] > ACC_W'(255)) begin
                chan_val[c] = 8'd255;
            end
            else begin
                chan_val[c] = acc_reg[c][7:0];
            end
        end
    end

    always_ff @(posedge clk) begin
        tap_wt_reg  <= tap_weight(ksel_reg, ty_reg, tx_reg);
        tap_ctr_reg <= (tx_reg == half) && (ty_reg == half);
        if (in_fire) begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            oor_reg <= !in_inside;
        end
        for (int c = 0; c < 3; c++) begin
            if (in_fire) begin
                acc_reg[c] <= '0;
            end
            else if (tap_vld_reg) begin
                acc_reg[c] <= acc_reg[c] + ACC_W'(tap_prod[c]);
            end
            if (state_reg == ST_SCALE) begin
                scaled_reg[c] <= 35'(acc_reg[c][16:0]) * 35'(GAUSS_RECIP);
            end
            if (out_load) begin
                res_reg[c] <= oor_reg ? 8'd0 : chan_val[c];
            end
        end
        if (tap_vld_reg && tap_ctr_reg) begin
            alpha_reg <= mem_rdata_reg[31:24];
        end
        if (out_load) begin
            out_alpha_reg <= oor_reg ? 8'd0 : alpha_reg;
            out_oor_reg   <= oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_red      = res_reg[0];
    assign out_green    = res_reg[1];
    assign out_blue     = res_reg[2];
    assign out_alpha    = out_alpha_reg;
    assign out_of_range = out_oor_reg;

endmodule

// ===== hdl/icrb_checker.sv =====
`timescale 1ns / 1ps

module icrb_checker
    import icrb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       cmd,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic [7:0] out_alpha,
    input logic       out_of_range
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
                                   && $stable(out_blue) && $stable(out_alpha)
                                   && $stable(out_of_range))
        else $error("stalled result beat changed");

    // An out-of-range read carries zeros in every channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> out_red == 8'd0 && out_green == 8'd0
                                      && out_blue == 8'd0 && out_alpha == 8'd0)
        else $error("out-of-range result with non-zero channels");

    // A read occupies the block, a pixel write does not.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_READ |=> in_stall)
        else $error("read beat did not hold the input off");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && cmd == CMD_WRITE |=> !in_stall)
        else $error("write beat held the input off");

    // A fresh result only appears at the end of a read, while the input is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a read in progress");

endmodule

bind image_convolution_replicate_border icrb_checker u_icrb_checker (.*);

// ===== tb/tb_image_convolution_replicate_border.sv =====
`timescale 1ns / 1ps

module tb_image_convolution_replicate_border;
    import icrb_pkg::*;

    // Store geometry; it matches the default parameters of the instance below.
    localparam int FRAME_SPAN = 256;
    // A write gives no result, so this margin lets the block settle after the last result
    // before the registers are touched again.
    localparam int DRAIN_CYCLES = 40;
    // A correct run stays far below this limit, even with every read held up by heavy
    // back-pressure and with long sender gaps.
    localparam int CYCLE_LIMIT = 1000000;
    // Random traffic stops once this many beats, directed rows included, have been taken.
    localparam int RANDOM_ITEMS = 400;
    localparam int GAUSS_NORM = 273;

    localparam int GAUSS_TAPS [5][5] = '{
        '{1,  4,  7,  4, 1},
        '{4, 16, 26, 16, 4},
        '{7, 26, 41, 26, 7},
        '{4, 16, 26, 16, 4},
        '{1,  4,  7,  4, 1}
    };

    typedef struct packed {
        logic       cmd;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_beat_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       oor;
    } filtered_t;

    // One row of the directed part: either a register setup or a single beat, the
    // latter optionally carrying a result typed in by hand.
    typedef struct {
        bit          is_setup;
        pixel_beat_t beat;
        logic [8:0]  width;
        logic [8:0]  height;
        logic        kernel;
        bit          typed;
        filtered_t   want;
    } plan_row_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_style_t;

    logic       clk;
    logic       rst_n = 1'b0;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       cmd = CMD_WRITE;
    logic [7:0] pos_x = '0;
    logic [7:0] pos_y = '0;
    logic [7:0] in_red = '0;
    logic [7:0] in_green = '0;
    logic [7:0] in_blue = '0;
    logic [7:0] in_alpha = '0;

    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       out_of_range;

    // Shadow of the block: its registers, its frame and a record of which pixels have
    // been written, so that no read window ever touches an unwritten pixel.
    logic [8:0]  width_reg = 9'd256;
    logic [8:0]  height_reg = 9'd256;
    logic        kernel_reg = KERNEL_EDGE;
    logic [31:0] frame_copy [FRAME_SPAN*FRAME_SPAN];
    bit          pixel_written [FRAME_SPAN*FRAME_SPAN];

    filtered_t   pending_pixels [$];
    plan_row_t   directed_plan [$];

    int          error_count = 0;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    stall_style_t stall_style = STALL_NONE;

    image_convolution_replicate_border #(
        .MAX_WIDTH (FRAME_SPAN),
        .MAX_HEIGHT(FRAME_SPAN)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .in_red      (in_red),
        .in_green    (in_green),
        .in_blue     (in_blue),
        .in_alpha    (in_alpha),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .out_of_range(out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Size registers above the store size behave as the store size.
    function automatic int eff_size(input logic [8:0] reg_value);
        return (reg_value > FRAME_SPAN) ? FRAME_SPAN : int'(reg_value);
    endfunction

    function automatic bit pixel_in_frame(input int x, input int y);
        return x < eff_size(width_reg) && y < eff_size(height_reg);
    endfunction

    function automatic int clamp_axis(input int v, input int lim);
        if (v < 0)
        begin
            return 0;
        end
        if (v >= lim)
        begin
            return lim - 1;
        end
        return v;
    endfunction

    // Expected outcome of a read at (x, y) under the current registers: kernel sum over
    // the edge-clamped window, Gaussian sums floored by the norm, all clamped to a byte.
    function automatic filtered_t filter_pixel(input int x, input int y);
        filtered_t   res;
        int          w;
        int          h;
        int          half;
        int          nx;
        int          ny;
        int          wt;
        int          v;
        int          sum [3];
        logic [7:0]  chan [3];
        logic [31:0] word;
        w = eff_size(width_reg);
        h = eff_size(height_reg);
        res = '0;
        if (!(x < w && y < h))
        begin
            res.oor = 1'b1;
            return res;
        end
        half = (kernel_reg == KERNEL_GAUSS) ? 2 : 1;
        sum = '{0, 0, 0};
        for (int ky = -half; ky <= half; ky++)
        begin
            for (int kx = -half; kx <= half; kx++)
            begin
                nx = clamp_axis(x + kx, w);
                ny = clamp_axis(y + ky, h);
                word = frame_copy[ny*FRAME_SPAN + nx];
                if (kernel_reg == KERNEL_GAUSS)
                begin
                    wt = GAUSS_TAPS[ky+2][kx+2];
                end
                else
                begin
                    wt = (ky == 0 && kx == 0) ? 8 : -1;
                end
                for (int c = 0; c < 3; c++)
                begin
                    sum[c] += wt * int'(word[8*c +: 8]);
                end
            end
        end
        for (int c = 0; c < 3; c++)
        begin
            v = sum[c];
            if (kernel_reg == KERNEL_GAUSS)
            begin
                v = v / GAUSS_NORM;
            end
            if (v > 255)
            begin
                v = 255;
            end
            if (v < 0)
            begin
                v = 0;
            end
            chan[c] = v[7:0];
        end
        res.red = chan[0];
        res.green = chan[1];
        res.blue = chan[2];
        res.alpha = frame_copy[y*FRAME_SPAN + x][31:24];
        return res;
    endfunction

    // Channel values lean towards the extremes now and then.
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_beat_t random_beat(input logic c, input int x, input int y);
        pixel_beat_t b;
        b.cmd = c;
        b.x = x[7:0];
        b.y = y[7:0];
        b.red = rand_byte();
        b.green = rand_byte();
        b.blue = rand_byte();
        b.alpha = rand_byte();
        return b;
    endfunction

    // Near the edges a good share of the time, since that is where clamping happens.
    function automatic int pick_coord(input int lim);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return lim - 1;
            default: return $urandom_range(0, lim - 1);
        endcase
    endfunction

    function automatic void plan_setup(input int w, input int h, input logic k);
        plan_row_t row;
        row = '{default: 0};
        row.is_setup = 1'b1;
        row.width = w[8:0];
        row.height = h[8:0];
        row.kernel = k;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_beat(input logic c, input int x, input int y, input int r,
                                      input int g, input int b, input int a);
        plan_row_t row;
        row = '{default: 0};
        row.beat = {c, x[7:0], y[7:0], r[7:0], g[7:0], b[7:0], a[7:0]};
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_typed_read(input int x, input int y, input int r,
                                            input int g, input int b, input int a,
                                            input logic oor);
        plan_row_t row;
        row = '{default: 0};
        row.beat = {CMD_READ, x[7:0], y[7:0], 32'h0};
        row.typed = 1'b1;
        row.want = {r[7:0], g[7:0], b[7:0], a[7:0], oor};
        directed_plan.push_back(row);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Leaves cfg_valid high so that a run of writes is back to back; the caller lowers it.
    task automatic cfg_write(input logic [1:0] idx, input logic [8:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_WIDTH: width_reg = value;
            REG_HEIGHT: height_reg = value;
            REG_KERNEL: kernel_reg = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [8:0] w, input logic [8:0] h, input logic k);
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_KERNEL, {8'd0, k});
        cfg_valid <= 1'b0;
    endtask

    // Offers one beat, holding it until it is taken. A new burst may open with a gap,
    // during which in_valid is low; inside a burst in_valid simply stays high.
    task automatic send_item(input pixel_beat_t beat, input bit typed, input filtered_t want);
        int gap;
        int idx;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 32);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd <= beat.cmd;
        pos_x <= beat.x;
        pos_y <= beat.y;
        in_red <= beat.red;
        in_green <= beat.green;
        in_blue <= beat.blue;
        in_alpha <= beat.alpha;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
        idx = int'(beat.y) * FRAME_SPAN + int'(beat.x);
        if (beat.cmd == CMD_WRITE)
        begin
            // Writes outside the configured image are dropped by the block.
            if (pixel_in_frame(beat.x, beat.y))
            begin
                frame_copy[idx] = {beat.alpha, beat.blue, beat.green, beat.red};
                pixel_written[idx] = 1'b1;
            end
        end
        else
        begin
            pending_pixels.push_back(typed ? want : filter_pixel(beat.x, beat.y));
        end
    endtask

    // Fills in any pixel of the read window that has not yet been written.
    task automatic ensure_window(input int x, input int y);
        int half;
        int nx;
        int ny;
        half = (kernel_reg == KERNEL_GAUSS) ? 2 : 1;
        for (int dy = -half; dy <= half; dy++)
        begin
            for (int dx = -half; dx <= half; dx++)
            begin
                nx = clamp_axis(x + dx, eff_size(width_reg));
                ny = clamp_axis(y + dy, eff_size(height_reg));
                if (!pixel_written[ny*FRAME_SPAN + nx])
                begin
                    send_item(random_beat(CMD_WRITE, nx, ny), 1'b0, '0);
                end
            end
        end
    endtask

    task automatic read_at(input int x, input int y);
        if (pixel_in_frame(x, y))
        begin
            ensure_window(x, y);
        end
        send_item(random_beat(CMD_READ, x, y), 1'b0, '0);
    endtask

    // Drops in_valid and waits for every outstanding result plus a settling margin.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register setting followed by a short run of traffic. Most sizes are small so that
    // windows fill quickly; some phases use the full store width or height, a single row or
    // column, oversized values that saturate, or a zero size that makes every pixel outside.
    task automatic random_phase();
        int   w;
        int   h;
        int   n;
        int   act;
        int   ew;
        int   eh;
        logic k;
        case ($urandom_range(0, 11))
            0: begin w = 256; h = $urandom_range(1, 256); end
            1: begin w = $urandom_range(1, 256); h = 256; end
            2: begin w = 1; h = $urandom_range(1, 16); end
            3: begin w = $urandom_range(1, 16); h = 1; end
            4: begin w = $urandom_range(257, 511); h = $urandom_range(1, 8); end
            5: begin w = $urandom_range(1, 8); h = $urandom_range(0, 1) ? 0 : 511; end
            default: begin w = $urandom_range(1, 12); h = $urandom_range(1, 12); end
        endcase
        k = $urandom_range(0, 1) ? KERNEL_GAUSS : KERNEL_EDGE;
        wait_idle();
        set_config(w[8:0], h[8:0], k);
        ew = eff_size(width_reg);
        eh = eff_size(height_reg);
        n = $urandom_range(8, 30);
        repeat (n)
        begin
            if (items_sent >= RANDOM_ITEMS)
            begin
                break;
            end
            act = $urandom_range(0, 19);
            if (ew == 0 || eh == 0)
            begin
                // Nothing lies inside: every beat is an out-of-range read or a dropped write.
                send_item(random_beat(act < 12 ? CMD_READ : CMD_WRITE,
                                      $urandom_range(0, 255), $urandom_range(0, 255)),
                          1'b0, '0);
            end
            else if (act < 11)
            begin
                read_at(pick_coord(ew), pick_coord(eh));
            end
            else if (act < 15)
            begin
                send_item(random_beat(CMD_WRITE, pick_coord(ew), pick_coord(eh)), 1'b0, '0);
            end
            else if (act < 17)
            begin
                if (ew < FRAME_SPAN)
                begin
                    read_at($urandom_range(ew, 255), $urandom_range(0, 255));
                end
                else if (eh < FRAME_SPAN)
                begin
                    read_at($urandom_range(0, 255), $urandom_range(eh, 255));
                end
                else
                begin
                    read_at($urandom_range(0, 255), $urandom_range(0, 255));
                end
            end
            else if (act < 19)
            begin
                send_item(random_beat(CMD_WRITE, $urandom_range(0, 255),
                                      $urandom_range(0, 255)), 1'b0, '0);
            end
            else
            begin
                read_at($urandom_range(0, 255), $urandom_range(0, 255));
            end
        end
    endtask

    // The receiver picks a stall style anew whenever its current stretch runs out, including
    // stretches in which it never stalls at all.
    always @(posedge clk)
    begin : receiver_stall
        if (stall_left == 0)
        begin
            stall_style = stall_style_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        else
        begin
            stall_left = stall_left - 1;
        end
        case (stall_style)
            STALL_NONE: out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_left % 7) < 3;
        endcase
    end

    // Every result beat is checked against the oldest outstanding expectation.
    always @(posedge clk)
    begin : result_check
        filtered_t seen;
        filtered_t want;
        seen = {out_red, out_green, out_blue, out_alpha, out_of_range};
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                report_mismatch("result beat with no read outstanding");
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (seen.red !== want.red)
                begin
                    report_mismatch($sformatf("out_red expected %0d got %0d",
                                              want.red, seen.red));
                end
                if (seen.green !== want.green)
                begin
                    report_mismatch($sformatf("out_green expected %0d got %0d",
                                              want.green, seen.green));
                end
                if (seen.blue !== want.blue)
                begin
                    report_mismatch($sformatf("out_blue expected %0d got %0d",
                                              want.blue, seen.blue));
                end
                if (seen.alpha !== want.alpha)
                begin
                    report_mismatch($sformatf("out_alpha expected %0d got %0d",
                                              want.alpha, seen.alpha));
                end
                if (seen.oor !== want.oor)
                begin
                    report_mismatch($sformatf("out_of_range expected %0d got %0d",
                                              want.oor, seen.oor));
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[image_convolution_replicate_border] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A 2 x 2 white image: the edge kernel cancels to zero on a flat patch, and any
        // coordinate past the configured size, up to the corner of the store, is out of range.
        plan_setup(2, 2, KERNEL_EDGE);
        plan_beat(CMD_WRITE, 0, 0, 255, 255, 255, 255);
        plan_beat(CMD_WRITE, 1, 0, 255, 255, 255, 255);
        plan_beat(CMD_WRITE, 0, 1, 255, 255, 255, 255);
        plan_beat(CMD_WRITE, 1, 1, 255, 255, 255, 255);
        plan_typed_read(0, 0, 0, 0, 0, 255, 1'b0);
        plan_typed_read(2, 0, 0, 0, 0, 0, 1'b1);
        plan_typed_read(255, 255, 0, 0, 0, 0, 1'b1);
        // A write just outside is dropped; a black centre then drives the edge sum negative
        // there and lifts it to exactly 255 at the white corner.
        plan_beat(CMD_WRITE, 2, 1, 0, 0, 0, 0);
        plan_beat(CMD_WRITE, 1, 1, 0, 0, 0, 0);
        plan_beat(CMD_READ, 1, 1, 0, 0, 0, 0);
        plan_beat(CMD_READ, 0, 0, 0, 0, 0, 0);
        plan_setup(2, 2, KERNEL_GAUSS);
        plan_beat(CMD_READ, 1, 0, 0, 0, 0, 0);
        // One column of full height, read at the bottom row with the 5 x 5 kernel.
        plan_setup(1, 256, KERNEL_GAUSS);
        plan_beat(CMD_WRITE, 0, 253, 8'h01, 8'h80, 8'hFE, 8'h7F);
        plan_beat(CMD_WRITE, 0, 254, 8'hAA, 8'h55, 8'hAA, 8'h55);
        plan_beat(CMD_WRITE, 0, 255, 8'h55, 8'hAA, 8'h55, 8'hAA);
        plan_beat(CMD_READ, 0, 255, 0, 0, 0, 0);
        plan_typed_read(1, 0, 0, 0, 0, 0, 1'b1);
        // One row of full width, read at the last column.
        plan_setup(256, 1, KERNEL_EDGE);
        plan_beat(CMD_WRITE, 254, 0, 8'hC3, 8'h3C, 8'h0F, 8'hF0);
        plan_beat(CMD_WRITE, 255, 0, 8'h81, 8'h7E, 8'hFF, 8'h00);
        plan_beat(CMD_READ, 255, 0, 0, 0, 0, 0);
        // Zero height with an oversized width, then zero width: nothing lies inside and
        // the dropped write must leave the stored corner pixel untouched.
        plan_setup(511, 0, KERNEL_EDGE);
        plan_typed_read(0, 0, 0, 0, 0, 0, 1'b1);
        plan_beat(CMD_WRITE, 0, 0, 8'h12, 8'h34, 8'h56, 8'h78);
        plan_setup(0, 256, KERNEL_GAUSS);
        plan_typed_read(128, 200, 0, 0, 0, 0, 1'b1);
        plan_setup(2, 2, KERNEL_GAUSS);
        plan_beat(CMD_READ, 0, 0, 0, 0, 0, 0);

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_setup)
            begin
                wait_idle();
                set_config(directed_plan[i].width, directed_plan[i].height,
                           directed_plan[i].kernel);
            end
            else
            begin
                send_item(directed_plan[i].beat, directed_plan[i].typed,
                          directed_plan[i].want);
            end
        end

        while (items_sent < RANDOM_ITEMS)
        begin
            random_phase();
        end

        wait_idle();
        if (error_count == 0)
        begin
            $display("[image_convolution_replicate_border] OK");
        end
        else
        begin
            $display("[image_convolution_replicate_border] ERROR");
        end
        $finish;
    end

endmodule

// ===== image_convolution_replicate_border.f =====
hdl/icrb_pkg.sv
hdl/image_convolution_replicate_border.sv
hdl/icrb_checker.sv
tb/tb_image_convolution_replicate_border.sv
